// ===== rtl/oaht_pkg.sv =====
// ----------------------------------------------------------------------------
// oaht_pkg: shared types and constants of the open-addressing hash table
// Request and response words, command and status groups between the
// controller and the datapath, and the table geometry.
// ----------------------------------------------------------------------------
package oaht_pkg;

    // Table geometry; the slot index is the low bits of the hash, so the
    // capacity is kept a power of two
    localparam int CAPACITY   = 256;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int OCC_W      = $clog2(CAPACITY + 1);
    // An insert into a truly empty slot is allowed while occupancy is below this
    localparam int FILL_LIMIT = (3 * CAPACITY) / 4;

    // Request modes
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_FIND   = 2'd2;

    // Response status codes
    localparam logic [2:0] ST_NEW     = 3'd0;
    localparam logic [2:0] ST_UPDATED = 3'd1;
    localparam logic [2:0] ST_FOUND   = 3'd2;
    localparam logic [2:0] ST_MISSING = 3'd3;
    localparam logic [2:0] ST_REMOVED = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] key_id;
        logic [31:0] key_hash;
        logic [63:0] value_in;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] value_out;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic start;         // latch request, set up probe
        logic read;          // read the slot under the probe index
        logic advance;       // step to the next slot
        logic commit;        // apply the decision, write the slot
        logic load_trivial;  // answer without probing
        logic out_load;      // move the result into the response register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic trivial;       // request needs no probe
        logic stop;          // probe ends at the slot just read
    } t_sts;

endpackage

// ===== rtl/oaht_ctrl.sv =====
// ----------------------------------------------------------------------------
// oaht_ctrl: probe sequencer
// Walks each request through slot read and evaluate steps and hands the
// result to the response register when the output side is free.
// ----------------------------------------------------------------------------
module oaht_ctrl
    import oaht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    logic   rsp_free;

    assign rsp_free    = !r_rsp_valid || i_rsp_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;

    // Decode commands and next state
    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid;
        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_READ;
                end
            end
            S_READ: begin
                if (i_sts.trivial) begin
                    o_cmd.load_trivial = 1'b1;
                    n_state            = S_RESP;
                end else begin
                    o_cmd.read = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.stop) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_RESP;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_RESP: begin
                if (rsp_free) begin
                    o_cmd.out_load = 1'b1;
                    n_rsp_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // One request in flight at a time
    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("second request accepted while one is in flight");

    // A pending response is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_rsp_valid || i_rsp_ready))
        else $error("response register loaded while still occupied");

    // A slot write only ends an evaluate step, never a read step
    a_commit_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> $past(o_cmd.read))
        else $error("commit without a preceding slot read");

endmodule

// ===== rtl/oaht_dpath.sv =====
// ----------------------------------------------------------------------------
// oaht_dpath: slot store and probe datapath
// Holds the slot memory with per-slot valid bits, the probe index and
// tombstone tracking, the occupancy count and the response register.
// ----------------------------------------------------------------------------
module oaht_dpath
    import oaht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_rsp o_rsp
);

    typedef struct packed {
        logic [31:0] key;
        logic        tomb;
        logic [63:0] value;
    } t_slot;

    // Slot memory; entries never written read as empty through the valid bits
    t_slot                 mem [CAPACITY];
    logic [CAPACITY-1:0]   r_valid;
    t_slot                 r_rd;
    logic                  r_rd_valid;

    // Request and probe registers
    logic [1:0]       r_mode;
    logic [31:0]      r_key;
    logic [63:0]      r_val;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_count;
    logic             r_have_tomb;
    logic [IDX_W-1:0] r_tomb_idx;
    logic [OCC_W-1:0] r_occ;
    logic [2:0]       r_status;
    logic [63:0]      r_vout;
    t_rsp             r_rsp;

    // Decision signals
    logic [31:0]      rd_key;
    logic             rd_tomb;
    logic [63:0]      rd_value;
    logic             is_empty, is_tomb, is_match, is_last;
    logic             have_tomb_n;
    logic [IDX_W-1:0] tomb_idx_n;
    logic             use_tomb, use_empty;
    logic             we;
    logic [IDX_W-1:0] waddr;
    t_slot            wdata;
    logic             occ_inc;
    logic [2:0]       res_status;
    logic [63:0]      res_vout;

    assign o_rsp         = r_rsp;

    // Classify the slot just read and decide the outcome
    always_comb begin
        o_sts.trivial = (r_mode != MODE_INSERT && r_mode != MODE_REMOVE
                         && r_mode != MODE_FIND) || (r_key == '0);
        rd_key      = r_rd_valid ? r_rd.key   : '0;
        rd_tomb     = r_rd_valid ? r_rd.tomb  : 1'b0;
        rd_value    = r_rd_valid ? r_rd.value : '0;
        is_empty    = (rd_key == '0) && !rd_tomb;
        is_tomb     = (rd_key == '0) && rd_tomb;
        is_match    = (rd_key != '0) && (rd_key == r_key);
        is_last     = (r_count == IDX_W'(CAPACITY - 1));
        o_sts.stop  = is_empty || is_match || is_last;
        have_tomb_n = r_have_tomb || is_tomb;
        tomb_idx_n  = r_have_tomb ? r_tomb_idx : r_idx;
        use_tomb    = !is_match && (is_empty ? r_have_tomb : have_tomb_n);
        use_empty   = !is_match && is_empty && !r_have_tomb;
        we          = 1'b0;
        waddr       = r_idx;
        wdata       = '{key: r_key, tomb: 1'b0, value: r_val};
        occ_inc     = 1'b0;
        res_status  = ST_MISSING;
        res_vout    = '0;
        unique case (r_mode)
            MODE_INSERT: begin
                if (is_match) begin
                    we         = 1'b1;
                    res_status = ST_UPDATED;
                end else if (use_tomb) begin
                    we         = 1'b1;
                    waddr      = tomb_idx_n;
                    res_status = ST_NEW;
                end else if (use_empty && (r_occ < OCC_W'(FILL_LIMIT))) begin
                    we         = 1'b1;
                    occ_inc    = 1'b1;
                    res_status = ST_NEW;
                end else begin
                    res_status = ST_FULL;
                end
            end
            MODE_REMOVE: begin
                if (is_match) begin
                    we         = 1'b1;
                    wdata      = '{key: '0, tomb: 1'b1, value: '0};
                    res_status = ST_REMOVED;
                end
            end
            MODE_FIND: begin
                if (is_match) begin
                    res_status = ST_FOUND;
                    res_vout   = rd_value;
                end
            end
            default: res_status = ST_MISSING;
        endcase
    end

    // Read and write the slot memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd <= mem[r_idx];
        end
        if (i_cmd.commit && we) begin
            mem[waddr] <= wdata;
        end
    end

    // Mark written slots valid; reset empties the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
        end else if (i_cmd.commit) begin
            if (we) begin
                r_valid[waddr] <= 1'b1;
            end
            if (occ_inc) begin
                r_occ <= r_occ + OCC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_valid <= r_valid[r_idx];
        end
    end

    // Latch the request, advance the probe, hold the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode      <= i_req.mode;
            r_key       <= i_req.key_id;
            r_val       <= i_req.value_in;
            r_idx       <= i_req.key_hash[IDX_W-1:0];
            r_count     <= '0;
            r_have_tomb <= 1'b0;
            r_tomb_idx  <= '0;
        end
        if (i_cmd.advance) begin
            r_idx       <= r_idx + IDX_W'(1);
            r_count     <= r_count + IDX_W'(1);
            r_have_tomb <= have_tomb_n;
            r_tomb_idx  <= tomb_idx_n;
        end
        if (i_cmd.load_trivial) begin
            r_status <= (r_mode == MODE_INSERT) ? ST_FULL : ST_MISSING;
            r_vout   <= '0;
        end
        if (i_cmd.commit) begin
            r_status <= res_status;
            r_vout   <= res_vout;
        end
        if (i_cmd.out_load) begin
            r_rsp.status    <= r_status;
            r_rsp.value_out <= r_vout;
        end
    end

    // Occupancy never passes the fill limit
    a_occ_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(FILL_LIMIT))
        else $error("occupancy above fill limit");

    // The probe never steps past a full lap of the table
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |-> !is_last)
        else $error("probe advanced beyond table capacity");

    // A value is only returned with a found status
    a_vout_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_vout == '0 || r_status == ST_FOUND))
        else $error("nonzero value with a status other than found");

endmodule

// ===== rtl/open_addressing_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// open_addressing_hash_table_core: linear-probing key/value table
// Insert, remove and find over a fixed table with tombstones, one request
// at a time, one response per request.
// ----------------------------------------------------------------------------
// A request occupies the block from acceptance to the next ready while
// it probes 1 to CAPACITY slots; a request with a zero key or an
// unknown mode is answered without probing. Each probed slot takes a
// read step and then an evaluate step, because the slot memory is
// single-port with a registered read. The response sits in its own
// register, so the next request is accepted while a response still waits.
// Reset empties the table at once through per-slot valid bits; there is no
// clearing pass.
module open_addressing_hash_table_core
    import oaht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    t_cmd cmd;
    t_sts sts;

    // Sequence the probe
    oaht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Store slots and evaluate them
    oaht_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

endmodule
